/* rtl/qgpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpu_pkg
// Shared widths, register indexes and types of the qubit gate pair update.
// ----------------------------------------------------------------------------
package qgpu_pkg;

  localparam int QUBITS     = 10;
  localparam int AMP_WIDTH  = 16;
  localparam int PAIR_WIDTH = QUBITS - 1;
  localparam int ADDR_WIDTH = QUBITS;
  localparam int COEF_WIDTH = 16;
  localparam int COEF_FRAC  = 14;
  localparam int CFG_WIDTH  = 2 * COEF_WIDTH;
  localparam int QSEL_WIDTH = 4;
  localparam int IDX_WIDTH  = 3;

  localparam int PROD_WIDTH = AMP_WIDTH + COEF_WIDTH;
  localparam int SH_WIDTH   = PROD_WIDTH - COEF_FRAC;
  localparam int SUM_WIDTH  = SH_WIDTH + 2;

  localparam logic [IDX_WIDTH-1:0] REG_TARGET  = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_CONTROL = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_MODE    = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_COEF_A  = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_COEF_B  = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_COEF_C  = 3'd5;
  localparam logic [IDX_WIDTH-1:0] REG_COEF_D  = 3'd6;

  localparam logic [CFG_WIDTH-1:0] COEF_ONE  = 32'h4000_0000;
  localparam logic [CFG_WIDTH-1:0] COEF_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic signed [AMP_WIDTH-1:0] re;
    logic signed [AMP_WIDTH-1:0] im;
  } amp_t;

  typedef struct packed {
    logic zero_write;
    logic one_write;
  } wr_flags_t;

endpackage

/* rtl/qubit_gate_pair_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_gate_pair_update
// Applies a configured 2x2 complex gate to one state vector amplitude pair.
// Stages: input register, then result register.
// Throughput: 1 item per cycle while out_ready is high (single gate stage).
// Reset: synchronous active low; both stages empty, gate registers set to
// identity, target and control at qubit 0, controlled mode off.
// ----------------------------------------------------------------------------
module qubit_gate_pair_update (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_we,
  input  logic [qgpu_pkg::IDX_WIDTH-1:0]  cfg_index,
  input  logic [qgpu_pkg::CFG_WIDTH-1:0]  cfg_data,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [qgpu_pkg::PAIR_WIDTH-1:0] in_pair_index,
  input  logic signed [qgpu_pkg::AMP_WIDTH-1:0] in_zero_re,
  input  logic signed [qgpu_pkg::AMP_WIDTH-1:0] in_zero_im,
  input  logic signed [qgpu_pkg::AMP_WIDTH-1:0] in_one_re,
  input  logic signed [qgpu_pkg::AMP_WIDTH-1:0] in_one_im,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qgpu_pkg::ADDR_WIDTH-1:0] out_zero_addr,
  output logic [qgpu_pkg::ADDR_WIDTH-1:0] out_one_addr,
  output logic signed [qgpu_pkg::AMP_WIDTH-1:0] out_new_zero_re,
  output logic signed [qgpu_pkg::AMP_WIDTH-1:0] out_new_zero_im,
  output logic signed [qgpu_pkg::AMP_WIDTH-1:0] out_new_one_re,
  output logic signed [qgpu_pkg::AMP_WIDTH-1:0] out_new_one_im,
  output logic                            out_zero_write,
  output logic                            out_one_write
);

  // configuration registers
  logic [qgpu_pkg::QSEL_WIDTH-1:0] target_r, control_r;
  logic                            mode_r;
  logic [qgpu_pkg::CFG_WIDTH-1:0]  coef_a_r, coef_b_r, coef_c_r, coef_d_r;

  // input stage
  logic                            s1_valid_r;
  logic [qgpu_pkg::PAIR_WIDTH-1:0] s1_pair_r;
  qgpu_pkg::amp_t                  s1_zero_r, s1_one_r;

  // result stage
  logic                            s2_valid_r;
  logic [qgpu_pkg::ADDR_WIDTH-1:0] s2_zaddr_r, s2_oaddr_r;
  qgpu_pkg::amp_t                  s2_new_zero_r, s2_new_one_r;
  qgpu_pkg::wr_flags_t             s2_flags_r;

  logic [qgpu_pkg::ADDR_WIDTH-1:0] zaddr_nxt, oaddr_nxt;
  qgpu_pkg::wr_flags_t             flags_nxt;
  qgpu_pkg::amp_t                  new_zero_nxt, new_one_nxt;
  logic                            s2_free, s1_move;

  assign s2_free  = !s2_valid_r || out_ready;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      control_r <= '0;
      mode_r    <= 1'b0;
      coef_a_r  <= qgpu_pkg::COEF_ONE;
      coef_b_r  <= qgpu_pkg::COEF_ZERO;
      coef_c_r  <= qgpu_pkg::COEF_ZERO;
      coef_d_r  <= qgpu_pkg::COEF_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        qgpu_pkg::REG_TARGET:  target_r  <= cfg_data[qgpu_pkg::QSEL_WIDTH-1:0];
        qgpu_pkg::REG_CONTROL: control_r <= cfg_data[qgpu_pkg::QSEL_WIDTH-1:0];
        qgpu_pkg::REG_MODE:    mode_r    <= cfg_data[0];
        qgpu_pkg::REG_COEF_A:  coef_a_r  <= cfg_data;
        qgpu_pkg::REG_COEF_B:  coef_b_r  <= cfg_data;
        qgpu_pkg::REG_COEF_C:  coef_c_r  <= cfg_data;
        qgpu_pkg::REG_COEF_D:  coef_d_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pair_r    <= in_pair_index;
      s1_zero_r.re <= in_zero_re;
      s1_zero_r.im <= in_zero_im;
      s1_one_r.re  <= in_one_re;
      s1_one_r.im  <= in_one_im;
    end
  end

  qgpu_addr u_addr (
    .pair_index      (s1_pair_r),
    .target_qubit    (target_r),
    .control_qubit   (control_r),
    .controlled_mode (mode_r),
    .zero_addr       (zaddr_nxt),
    .one_addr        (oaddr_nxt),
    .flags           (flags_nxt)
  );

  qgpu_cmac u_cmac_zero (
    .coef_p (coef_a_r),
    .coef_q (coef_b_r),
    .amp_x  (s1_zero_r),
    .amp_y  (s1_one_r),
    .result (new_zero_nxt)
  );

  qgpu_cmac u_cmac_one (
    .coef_p (coef_c_r),
    .coef_q (coef_d_r),
    .amp_x  (s1_zero_r),
    .amp_y  (s1_one_r),
    .result (new_one_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_zaddr_r    <= zaddr_nxt;
      s2_oaddr_r    <= oaddr_nxt;
      s2_new_zero_r <= new_zero_nxt;
      s2_new_one_r  <= new_one_nxt;
      s2_flags_r    <= flags_nxt;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_zero_addr   = s2_zaddr_r;
  assign out_one_addr    = s2_oaddr_r;
  assign out_new_zero_re = s2_new_zero_r.re;
  assign out_new_zero_im = s2_new_zero_r.im;
  assign out_new_one_re  = s2_new_one_r.re;
  assign out_new_one_im  = s2_new_one_r.im;
  assign out_zero_write  = s2_flags_r.zero_write;
  assign out_one_write   = s2_flags_r.one_write;

endmodule

/* rtl/qgpu_addr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpu_addr
// Expands a pair index into its two state addresses and derives write flags.
// ----------------------------------------------------------------------------
module qgpu_addr (
  input  logic [qgpu_pkg::PAIR_WIDTH-1:0] pair_index,
  input  logic [qgpu_pkg::QSEL_WIDTH-1:0] target_qubit,
  input  logic [qgpu_pkg::QSEL_WIDTH-1:0] control_qubit,
  input  logic                            controlled_mode,
  output logic [qgpu_pkg::ADDR_WIDTH-1:0] zero_addr,
  output logic [qgpu_pkg::ADDR_WIDTH-1:0] one_addr,
  output qgpu_pkg::wr_flags_t             flags
);

  localparam logic [qgpu_pkg::QSEL_WIDTH-1:0] TOP_QUBIT =
    qgpu_pkg::QSEL_WIDTH'(qgpu_pkg::QUBITS - 1);
  localparam logic [qgpu_pkg::QSEL_WIDTH:0] QUBIT_COUNT =
    (qgpu_pkg::QSEL_WIDTH + 1)'(qgpu_pkg::QUBITS);

  logic [qgpu_pkg::QSEL_WIDTH-1:0] tgt;
  logic [qgpu_pkg::ADDR_WIDTH-1:0] idx_ext;
  logic [qgpu_pkg::ADDR_WIDTH-1:0] low_mask;
  logic [qgpu_pkg::ADDR_WIDTH-1:0] zsh;
  logic [qgpu_pkg::ADDR_WIDTH-1:0] osh;
  logic                            ctl_ok;

  always_comb begin
    tgt      = (target_qubit > TOP_QUBIT) ? TOP_QUBIT : target_qubit;
    idx_ext  = {1'b0, pair_index};
    low_mask = (qgpu_pkg::ADDR_WIDTH'(1) << tgt) - qgpu_pkg::ADDR_WIDTH'(1);
    zero_addr = (idx_ext & low_mask) | ((idx_ext & ~low_mask) << 1);
    one_addr  = zero_addr | (qgpu_pkg::ADDR_WIDTH'(1) << tgt);
    zsh    = zero_addr >> control_qubit;
    osh    = one_addr >> control_qubit;
    ctl_ok = ({1'b0, control_qubit} < QUBIT_COUNT);
    if (controlled_mode) begin
      flags.zero_write = ctl_ok & zsh[0];
      flags.one_write  = ctl_ok & osh[0];
    end else begin
      flags.zero_write = 1'b1;
      flags.one_write  = 1'b1;
    end
  end

endmodule

/* rtl/qgpu_cmac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpu_cmac
// Complex multiply-accumulate p*x + q*y with floor-shifted products and
// saturation to the amplitude width.
// ----------------------------------------------------------------------------
module qgpu_cmac (
  input  logic [qgpu_pkg::CFG_WIDTH-1:0] coef_p,
  input  logic [qgpu_pkg::CFG_WIDTH-1:0] coef_q,
  input  qgpu_pkg::amp_t                 amp_x,
  input  qgpu_pkg::amp_t                 amp_y,
  output qgpu_pkg::amp_t                 result
);

  localparam int CW = qgpu_pkg::COEF_WIDTH;
  localparam int PW = qgpu_pkg::PROD_WIDTH;
  localparam int SW = qgpu_pkg::SH_WIDTH;
  localparam int UW = qgpu_pkg::SUM_WIDTH;
  localparam int AW = qgpu_pkg::AMP_WIDTH;
  localparam int FR = qgpu_pkg::COEF_FRAC;

  logic signed [CW-1:0] pr, pi, qr, qi;
  logic signed [PW-1:0] m_prxr, m_pixi, m_qryr, m_qiyi;
  logic signed [PW-1:0] m_prxi, m_pixr, m_qryi, m_qiyr;
  logic signed [UW-1:0] sum_re, sum_im;

  function automatic logic signed [UW-1:0] floor_shift(input logic signed [PW-1:0] v);
    logic signed [SW-1:0] s;
    s = signed'(v[PW-1:FR]);
    return UW'(s);
  endfunction

  function automatic logic signed [AW-1:0] saturate(input logic signed [UW-1:0] v);
    logic signed [AW-1:0] r;
    if ((&v[UW-1:AW-1]) || !(|v[UW-1:AW-1])) begin
      r = v[AW-1:0];
    end else if (v[UW-1]) begin
      r = {1'b1, {(AW-1){1'b0}}};
    end else begin
      r = {1'b0, {(AW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    pr = signed'(coef_p[2*CW-1:CW]);
    pi = signed'(coef_p[CW-1:0]);
    qr = signed'(coef_q[2*CW-1:CW]);
    qi = signed'(coef_q[CW-1:0]);

    m_prxr = PW'(pr) * PW'(amp_x.re);
    m_pixi = PW'(pi) * PW'(amp_x.im);
    m_qryr = PW'(qr) * PW'(amp_y.re);
    m_qiyi = PW'(qi) * PW'(amp_y.im);
    m_prxi = PW'(pr) * PW'(amp_x.im);
    m_pixr = PW'(pi) * PW'(amp_x.re);
    m_qryi = PW'(qr) * PW'(amp_y.im);
    m_qiyr = PW'(qi) * PW'(amp_y.re);

    sum_re = floor_shift(m_prxr) - floor_shift(m_pixi)
           + floor_shift(m_qryr) - floor_shift(m_qiyi);
    sum_im = floor_shift(m_prxi) + floor_shift(m_pixr)
           + floor_shift(m_qryi) + floor_shift(m_qiyr);

    result.re = saturate(sum_re);
    result.im = saturate(sum_im);
  end

endmodule
